// ----- rtl/flos_pkg.sv -----
// Shared widths, codes and constants for the first/last occurrence search block.
package flos_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 11;
    localparam int WPOS_W    = 10;
    localparam int LEN_W     = 11;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Position reported when the key is absent (minus one in eleven bits).
    localparam logic [POS_W-1:0] NONE_POS = {POS_W{1'b1}};

endpackage

// ----- rtl/flos_mem.sv -----
// Value store: one write port and one registered read port.
module flos_mem
    import flos_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [VAL_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/flos_search.sv -----
// Bisection sequencer: one or two probe passes over the value store, plus the result register.
module flos_search
    import flos_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [VAL_W-1:0] i_key,
    input  logic [LEN_W-1:0] i_len,
    output logic             o_idle,
    output logic             o_rd_en,
    output logic [AW-1:0]    o_rd_addr,
    input  logic [VAL_W-1:0] i_rd_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_found,
    output logic [POS_W-1:0] o_first_position,
    output logic [POS_W-1:0] o_last_position
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PROBE = 4'b0010,
        S_CMP   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    logic [POS_W-1:0] r_lo, n_lo;
    logic [POS_W-1:0] r_hi, n_hi;
    logic [POS_W-1:0] r_mid, n_mid;
    logic [LEN_W-1:0] r_n, n_n;
    logic [VAL_W-1:0] r_key, n_key;
    logic             r_pass, n_pass;
    logic             r_hit_vld, n_hit_vld;
    logic [POS_W-1:0] r_hit, n_hit;
    logic             r_found, n_found;
    logic [POS_W-1:0] r_first, n_first;
    logic             r_out_found, n_out_found;
    logic [POS_W-1:0] r_out_first, n_out_first;
    logic [POS_W-1:0] r_out_last, n_out_last;

    logic [POS_W-1:0]    w_mid;
    logic [AW+POS_W-1:0] w_mid_ext;
    logic                w_range;

    // The upper bound is held exclusive, so the range is empty when low meets it.
    assign w_range   = r_lo < r_hi;
    assign w_mid     = r_lo + ((r_hi - r_lo - POS_W'(1)) >> 1);
    assign w_mid_ext = {{AW{1'b0}}, w_mid};

    assign o_idle    = (r_state == S_IDLE);
    assign o_rd_en   = (r_state == S_PROBE) && w_range;
    assign o_rd_addr = w_mid_ext[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_n         = r_n;
        n_key       = r_key;
        n_pass      = r_pass;
        n_hit_vld   = r_hit_vld;
        n_hit       = r_hit;
        n_found     = r_found;
        n_first     = r_first;
        n_out_found = r_out_found;
        n_out_first = r_out_first;
        n_out_last  = r_out_last;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_lo      = '0;
                    n_hi      = i_len;
                    n_n       = i_len;
                    n_key     = i_key;
                    n_pass    = 1'b0;
                    n_hit_vld = 1'b0;
                    n_found   = 1'b0;
                    n_state   = S_PROBE;
                end
            end
            S_PROBE: begin
                if (w_range) begin
                    n_mid   = w_mid;
                    n_state = S_CMP;
                end else if (!r_pass && r_hit_vld) begin
                    // First occurrence known: restart over the whole range for the last one.
                    n_found   = 1'b1;
                    n_first   = r_hit;
                    n_pass    = 1'b1;
                    n_lo      = '0;
                    n_hi      = r_n;
                    n_hit_vld = 1'b0;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CMP: begin
                if (i_rd_data == r_key) begin
                    n_hit_vld = 1'b1;
                    n_hit     = r_mid;
                    if (r_pass) begin
                        n_lo = r_mid + POS_W'(1);
                    end else begin
                        n_hi = r_mid;
                    end
                end else if ($signed(i_rd_data) < $signed(r_key)) begin
                    n_lo = r_mid + POS_W'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_PROBE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_first = r_found ? r_first : NONE_POS;
                    n_out_last  = (r_found && r_hit_vld) ? r_hit : NONE_POS;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_n         <= n_n;
        r_key       <= n_key;
        r_pass      <= n_pass;
        r_hit_vld   <= n_hit_vld;
        r_hit       <= n_hit;
        r_found     <= n_found;
        r_first     <= n_first;
        r_out_found <= n_out_found;
        r_out_first <= n_out_first;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_out_found;
    assign o_first_position = r_out_first;
    assign o_last_position  = r_out_last;

endmodule

// ----- rtl/first_last_occurrence_search_top.sv -----
// Top level of the first/last occurrence search over a stored sorted array.
// A query over n entries runs a bisection of at most P = ceil(log2(n+1)) probes for the first
// occurrence and, only when the key is found, a second one for the last. Each probe reads the
// store, then compares; each pass closes when its range is empty, and then the result is loaded.
// The next word is accepted once the sequencer is back in idle; a waiting result stalls.
// Synchronous active-low reset clears sequencer state, result valid and length; not the store.
module first_last_occurrence_search_top
    import flos_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [LEN_W-1:0]        i_cfg_array_length,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_op,
    input  logic [WPOS_W-1:0]       i_position,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_found,
    output logic signed [POS_W-1:0] o_first_position,
    output logic signed [POS_W-1:0] o_last_position
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [LEN_W-1:0] r_array_length;
    logic [LEN_W-1:0] w_len_eff;
    logic             w_in_acc;
    logic             w_mem_we;
    logic             w_start;
    logic             w_idle;
    logic [AW+WPOS_W-1:0] w_pos_ext;
    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr;
    logic [VAL_W-1:0] w_rd_data;
    logic [POS_W-1:0] w_first;
    logic [POS_W-1:0] w_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_array_length <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_array_length <= i_cfg_array_length;
        end
    end

    // A length beyond the store is searched as the whole store.
    assign w_len_eff = (32'(r_array_length) > DEPTH) ? LEN_W'(DEPTH) : r_array_length;

    assign o_in_ready = w_idle;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_start    = w_in_acc && (i_op == OP_QUERY);
    assign w_mem_we   = w_in_acc && (i_op == OP_WRITE) && (32'(i_position) < DEPTH);
    assign w_pos_ext  = {{AW{1'b0}}, i_position};

    flos_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_pos_ext[AW-1:0]),
        .i_wdata (i_value),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    flos_search #(
        .DEPTH (DEPTH)
    ) u_search (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (w_start),
        .i_key            (i_value),
        .i_len            (w_len_eff),
        .o_idle           (w_idle),
        .o_rd_en          (w_rd_en),
        .o_rd_addr        (w_rd_addr),
        .i_rd_data        (w_rd_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_found          (o_found),
        .o_first_position (w_first),
        .o_last_position  (w_last)
    );

    assign o_first_position = w_first;
    assign o_last_position  = w_last;

`ifndef ASSERT_OFF
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !o_in_ready)
        else $error("sequencer still accepting words after a query started");

    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |->
            (w_first == NONE_POS) && (w_last == NONE_POS))
        else $error("positions reported for an absent key");

    a_first_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (w_first < w_len_eff))
        else $error("first position outside the searched range");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the first/last occurrence search block.
module testbench;
    import flos_pkg::*;

    localparam int CYCLE_LIMIT  = 1_200_000;
    localparam int SETTLE       = 64;
    localparam int RANDOM_WORDS = 380;
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef struct {
        logic signed [VAL_W-1:0] key;
        logic                    found;
        logic [POS_W-1:0]        first_pos;
        logic [POS_W-1:0]        last_pos;
    } t_search_result;

    class SearchTracker;
        logic signed [VAL_W-1:0] store [DEPTH_DEF];
        int unsigned             length_reg;
        t_search_result          awaited [$];
        int                      errors;
        int                      writes;
        int                      queries;
        int                      hits;
        int                      checked;

        function new();
            foreach (store[i]) store[i] = '0;
            length_reg = 0;
            errors = 0;
            writes = 0;
            queries = 0;
            hits = 0;
            checked = 0;
        endfunction

        // Lengths above the store depth search the whole store.
        function int span();
            return (length_reg > DEPTH_DEF) ? DEPTH_DEF : int'(length_reg);
        endfunction

        function int bisect(logic signed [VAL_W-1:0] key, bit want_last);
            int low;
            int high;
            int mid;
            int hit;
            low = 0;
            high = span() - 1;
            hit = -1;
            while (low <= high) begin
                mid = low + (high - low) / 2;
                if (store[mid] == key) begin
                    hit = mid;
                    if (want_last) low = mid + 1;
                    else high = mid - 1;
                end else if (store[mid] < key) begin
                    low = mid + 1;
                end else begin
                    high = mid - 1;
                end
            end
            return hit;
        endfunction

        function void note_word(logic op, logic [WPOS_W-1:0] pos, logic signed [VAL_W-1:0] val);
            t_search_result r;
            int first_hit;
            int last_hit;
            if (op == OP_WRITE) begin
                store[pos] = val;
                writes++;
                return;
            end
            queries++;
            first_hit = bisect(val, 1'b0);
            last_hit = (first_hit < 0) ? -1 : bisect(val, 1'b1);
            r.key = val;
            r.found = (first_hit >= 0);
            r.first_pos = first_hit[POS_W-1:0];
            r.last_pos = last_hit[POS_W-1:0];
            if (r.found) hits++;
            awaited.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic found, logic [POS_W-1:0] first_pos, logic [POS_W-1:0] last_pos);
            t_search_result want;
            if (awaited.size() == 0) begin
                report("result word arrived with no query outstanding");
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (found !== want.found)
                report($sformatf("key %0d: found %b, expected %b", want.key, found, want.found));
            if (first_pos !== want.first_pos)
                report($sformatf("key %0d: first position %h, expected %h",
                                 want.key, first_pos, want.first_pos));
            if (last_pos !== want.last_pos)
                report($sformatf("key %0d: last position %h, expected %h",
                                 want.key, last_pos, want.last_pos));
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [LEN_W-1:0]        i_cfg_array_length;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic                    i_op;
    logic [WPOS_W-1:0]       i_position;
    logic signed [VAL_W-1:0] i_value;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic                    o_found;
    logic signed [POS_W-1:0] o_first_position;
    logic signed [POS_W-1:0] o_last_position;

    SearchTracker tracker;
    int           cycle_count = 0;
    int           words_sent = 0;
    int           settings_used = 0;
    bit           calm = 1'b0;

    first_last_occurrence_search_top #(.DEPTH(DEPTH_DEF)) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_array_length (i_cfg_array_length),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_op               (i_op),
        .i_position         (i_position),
        .i_value            (i_value),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_found            (o_found),
        .o_first_position   (o_first_position),
        .o_last_position    (o_last_position)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_result(o_found, o_first_position, o_last_position);
    end

    // Mostly short gaps, now and then a long one; none at all in calm phases.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 0;
        if (r < 16) return 1;
        if (r < 22) return DEPTH_DEF;
        if (r < 27) return (1 << LEN_W) - 1;
        if (r < 31) return $urandom_range(DEPTH_DEF + 1, (1 << LEN_W) - 2);
        if (r < 36) return $urandom_range(65, DEPTH_DEF - 1);
        return $urandom_range(2, 64);
    endfunction

    // Keys are mostly stored values or their neighbours, so that hits are common.
    function automatic logic signed [VAL_W-1:0] pick_key();
        int n;
        int r;
        logic signed [VAL_W-1:0] k;
        n = tracker.span();
        r = $urandom_range(0, 99);
        if (n > 0 && r < 55) begin
            k = tracker.store[$urandom_range(0, n - 1)];
        end else if (n > 0 && r < 70) begin
            k = tracker.store[$urandom_range(0, n - 1)];
            if ($urandom_range(0, 1)) k = k + 1;
            else k = k - 1;
        end else if (r < 78) begin
            k = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
        end else if (r < 85) begin
            k = $urandom_range(0, 1) ? 0 : -1;
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    task automatic send_word(logic op, logic [WPOS_W-1:0] pos, logic signed [VAL_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_op = op;
        i_position = pos;
        i_value = val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.note_word(op, pos, val);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_word(logic [WPOS_W-1:0] pos, logic signed [VAL_W-1:0] val);
        send_word(OP_WRITE, pos, val);
    endtask

    // The position field is ignored by queries, so it carries random bits.
    task automatic query(logic signed [VAL_W-1:0] key);
        send_word(OP_QUERY, WPOS_W'($urandom_range(0, DEPTH_DEF - 1)), key);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (tracker.awaited.size() != 0) @(negedge i_clk);
    endtask

    // Writes never answer, so only query results are waited for before the pause and the new length.
    task automatic set_length(int len);
        drain();
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_array_length = len[LEN_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.length_reg = 32'(len[LEN_W-1:0]);
        settings_used++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Writes a non-decreasing run with repeats into slots 0..n-1, no value above hi.
    task automatic write_sorted_run(int n, longint lo, longint hi, bit pin_ends);
        longint cur;
        longint width;
        longint step_cap;
        int i;
        width = hi - lo;
        step_cap = width / n + 1;
        cur = pin_ends ? lo : lo + (longint'($urandom) % (width / 2 + 1));
        for (i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(0, 99) >= 35)
                cur = cur + (longint'($urandom) % step_cap);
            if (cur > hi || (pin_ends && i == n - 1)) cur = hi;
            write_word(i[WPOS_W-1:0], cur[VAL_W-1:0]);
        end
    endtask

    initial begin
        int base;
        int len;
        int n;
        int r;
        int forced [$];
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_array_length = '0;
        i_in_valid = 1'b0;
        i_op = OP_WRITE;
        i_position = '0;
        i_value = '0;
        tracker = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Length is zero after reset, so nothing can be found.
        query(0);
        write_word(WPOS_W'(0), VAL_MIN);
        write_word(WPOS_W'(DEPTH_DEF - 1), VAL_MAX);
        query(VAL_MIN);
        set_length(1);
        query(VAL_MIN);
        query(VAL_MAX);
        query(0);
        write_word(WPOS_W'(1), VAL_MIN);
        write_word(WPOS_W'(2), VAL_MIN);
        write_word(WPOS_W'(3), VAL_MAX);
        write_word(WPOS_W'(4), VAL_MAX);
        set_length(5);
        query(VAL_MIN);
        query(VAL_MAX);
        query(-1);
        // Out of order entries: the bisections run as they are.
        write_word(WPOS_W'(2), 100);
        write_word(WPOS_W'(4), -100);
        query(100);
        query(-100);
        query(VAL_MAX);

        // Fill the whole store in order so that any length is safe to search from now on.
        write_sorted_run(DEPTH_DEF, longint'(VAL_MIN), longint'(VAL_MAX), 1'b1);

        forced = '{(1 << LEN_W) - 1, DEPTH_DEF, 0, DEPTH_DEF + 1, 1};
        base = words_sent;
        while (words_sent - base < RANDOM_WORDS) begin
            len = (forced.size() != 0) ? forced.pop_front() : pick_length();
            calm = ($urandom_range(0, 4) == 0);
            set_length(len);
            n = tracker.span();
            // A fresh run no higher than the next stored entry keeps the store in order.
            if (n >= 1 && n <= 64)
                write_sorted_run(n, longint'(VAL_MIN), longint'(tracker.store[n]), 1'b0);
            repeat ($urandom_range(8, 30)) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    if (n > 0 && $urandom_range(0, 1))
                        write_word(WPOS_W'($urandom_range(0, n - 1)), $urandom);
                    else
                        write_word(WPOS_W'($urandom_range(0, DEPTH_DEF - 1)), $urandom);
                end else begin
                    if (r < 9) drain();
                    query(pick_key());
                end
            end
        end

        drain();
        repeat (SETTLE) @(negedge i_clk);
        $display("Sent %0d writes and %0d queries (%0d found, %0d absent) over %0d lengths.",
                 tracker.writes, tracker.queries, tracker.hits,
                 tracker.queries - tracker.hits, settings_used);
        $display("Compared %0d result words, %0d mismatches.", tracker.checked, tracker.errors);
        if (tracker.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 cycle_count, tracker.awaited.size());
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random stalls of varied length between runs of readiness.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    end

endmodule
